@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SERS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SERS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sers_pkg.sv @@
`default_nettype none
package sers_pkg;

   localparam int IDX_W          = 10;
   localparam int LEN_W          = 11;
   localparam int DEPTH_DEF      = 1024;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int RSP_DATA_W     = ((2 * IDX_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_IDX_W      = CSR_ADDR_W - 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CSR_IDX_W-1:0] REG_USED_LENGTH = '0;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

endpackage
`default_nettype wire

@@ rtl/sers_ram.sv @@
`default_nettype none
module sers_ram #(
   parameter int WIDTH = sers_pkg::WORD_WIDTH_DEF,
   parameter int DEPTH = sers_pkg::DEPTH_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
   input  wire logic [WIDTH-1:0]                           wdata,
   output logic      [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

@@ rtl/sorted_equal_range_search.sv @@
`default_nettype none
// Channel   | Direction | Payload
// ----------+-----------+--------------------------------------------------------
// req_      | in        | tuser: func; tdata: slot_index, element_value, search_value
// rsp_      | out       | tuser: found; tdata: first_index, last_index
// csr_      | in/out    | used_length at byte address 0
//
// A query runs two binary searches, one probe at a time (about 2*ceil(log2(n+1))
// probes, n being used_length capped at DEPTH, so 22 at n 1024), then loads the
// result register; each probe is one read of the single-port store RAM. A result
// waiting on rsp_tready blocks the next query from finishing but not its
// acceptance. Reset clears used_length; store contents are undefined until
// written.
module sorted_equal_range_search #(
   parameter int DEPTH      = sers_pkg::DEPTH_DEF,
   parameter int WORD_WIDTH = sers_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   // req_tdata: slot_index, element_value, search_value, zero pad
   input  wire logic                                              req_tvalid,
   output logic                                                   req_tready,
   input  wire logic [((sers_pkg::IDX_W + 2*WORD_WIDTH + 7)/8)*8-1:0] req_tdata,
   // req_tuser: func
   input  wire logic                                              req_tuser,
   output logic                                                   rsp_tvalid,
   input  wire logic                                              rsp_tready,
   // rsp_tdata: first_index, last_index, zero pad
   output logic      [sers_pkg::RSP_DATA_W-1:0]                   rsp_tdata,
   // rsp_tuser: found
   output logic                                                   rsp_tuser,
   input  wire logic                                              csr_psel,
   input  wire logic                                              csr_penable,
   input  wire logic                                              csr_pwrite,
   input  wire logic [sers_pkg::CSR_ADDR_W-1:0]                   csr_paddr,
   input  wire logic [sers_pkg::CSR_DATA_W-1:0]                   csr_pwdata,
   output logic      [sers_pkg::CSR_DATA_W-1:0]                   csr_prdata,
   output logic                                                   csr_pready
);

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W = sers_pkg::IDX_W;
   localparam int LEN_W = sers_pkg::LEN_W;

   typedef enum logic [1:0] {ST_IDLE, ST_PROBE, ST_DONE} state_type;

   state_type               state_ff, state_in;
   logic [LEN_W-1:0]        used_ff, used_in;
   logic [LEN_W-1:0]        n_ff, n_in;
   logic [LEN_W-1:0]        left_ff, left_in;
   logic [LEN_W-1:0]        right_ff, right_in;
   logic [LEN_W-1:0]        mid_ff, mid_in;
   logic [LEN_W-1:0]        lo_ff, lo_in;
   logic                    upper_ff, upper_in;
   logic                    lo_hit_ff, lo_hit_in;
   logic                    hi_hit_ff, hi_hit_in;
   logic signed [WORD_WIDTH-1:0] target_ff, target_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        first_ff, first_in;
   logic [IDX_W-1:0]        last_ff, last_in;

   logic [IDX_W-1:0]        req_slot;
   logic signed [WORD_WIDTH-1:0] req_element;
   logic signed [WORD_WIDTH-1:0] req_search;
   logic                    req_fire;
   logic                    csr_we;
   logic [LEN_W-1:0]        n_new;
   logic                    ram_we;
   logic [AW-1:0]           ram_addr;
   logic [WORD_WIDTH-1:0]   ram_rdata;
   logic signed [WORD_WIDTH-1:0] probe;
   logic                    probe_gt, probe_eq, go_right, range_hit;
   logic [LEN_W-1:0]        nl, nr, mid_nx;

   assign req_slot    = req_tdata[IDX_W-1:0];
   assign req_element = req_tdata[IDX_W +: WORD_WIDTH];
   assign req_search  = req_tdata[IDX_W + WORD_WIDTH +: WORD_WIDTH];
   assign req_tready  = (state_ff == ST_IDLE);
   assign req_fire    = req_tvalid && req_tready;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[sers_pkg::CSR_ADDR_W-1:2] == sers_pkg::REG_USED_LENGTH);
   assign csr_prdata = (csr_paddr[sers_pkg::CSR_ADDR_W-1:2] == sers_pkg::REG_USED_LENGTH)
                       ? sers_pkg::CSR_DATA_W'(used_ff) : '0;
   assign used_in    = csr_we ? csr_pwdata[LEN_W-1:0] : used_ff;

   assign n_new = (32'(used_ff) > DEPTH) ? LEN_W'(DEPTH) : used_ff;

   assign probe     = $signed(ram_rdata);
   assign probe_gt  = probe > target_ff;
   assign probe_eq  = probe == target_ff;
   assign go_right  = probe_gt || (!upper_ff && probe_eq);
   assign nl        = go_right ? left_ff : mid_ff + LEN_W'(1);
   assign nr        = go_right ? mid_ff : right_ff;
   assign mid_nx    = nl + ((nr - LEN_W'(1) - nl) >> 1);
   assign range_hit = lo_hit_ff && hi_hit_ff && (lo_ff < left_ff);

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      lo_in        = lo_ff;
      upper_in     = upper_ff;
      lo_hit_in    = lo_hit_ff;
      hi_hit_in    = hi_hit_ff;
      target_in    = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      ram_we       = 1'b0;
      ram_addr     = AW'(req_slot);
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == sers_pkg::FUNC_WRITE) begin
                  ram_we = (32'(req_slot) < DEPTH);
               end else begin
                  n_in      = n_new;
                  target_in = req_search;
                  upper_in  = 1'b0;
                  left_in   = '0;
                  right_in  = n_new;
                  lo_hit_in = 1'b0;
                  hi_hit_in = 1'b0;
                  mid_in    = (n_new - LEN_W'(1)) >> 1;
                  ram_addr  = AW'((n_new - LEN_W'(1)) >> 1);
                  state_in  = (n_new == '0) ? ST_DONE : ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            left_in  = nl;
            right_in = nr;
            if (go_right && !upper_ff) begin
               lo_hit_in = probe_eq;
            end
            if (!go_right && upper_ff) begin
               hi_hit_in = probe_eq;
            end
            if (nl < nr) begin
               mid_in   = mid_nx;
               ram_addr = AW'(mid_nx);
            end else if (!upper_ff) begin
               lo_in    = nr;
               upper_in = 1'b1;
               left_in  = '0;
               right_in = n_ff;
               mid_in   = (n_ff - LEN_W'(1)) >> 1;
               ram_addr = AW'((n_ff - LEN_W'(1)) >> 1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               found_in     = range_hit;
               first_in     = range_hit ? lo_ff[IDX_W-1:0] : '0;
               last_in      = range_hit ? IDX_W'(left_ff - LEN_W'(1)) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      mid_ff       <= mid_in;
      lo_ff        <= lo_in;
      upper_ff     <= upper_in;
      lo_hit_ff    <= lo_hit_in;
      hi_hit_ff    <= hi_hit_in;
      target_ff    <= target_in;
      found_ff     <= found_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
   end

   sers_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_element),
      .rdata (ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = sers_pkg::RSP_DATA_W'({last_ff, first_ff});

endmodule
`default_nettype wire

@@ rtl/sers_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
module sers_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [sers_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                            rsp_tuser
);

   localparam int IDX_W = sers_pkg::IDX_W;

   `SERS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "response changed while stalled")
   `SERS_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0, "miss carries nonzero indexes")
   `SERS_ASSERT(a_hit_order, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[IDX_W-1:0] <= rsp_tdata[2*IDX_W-1:IDX_W], "first index above last index")
   `SERS_ASSERT(a_query_busy, clock, reset, req_tvalid && req_tready && (req_tuser == sers_pkg::FUNC_QUERY) |=> !req_tready, "request taken during a search")
   `SERS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid, "response valid after reset")

endmodule

bind sorted_equal_range_search sers_checker u_sers_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ tb/tb_sorted_equal_range_search.sv @@
`timescale 1ns / 1ps
module tb_sorted_equal_range_search;

   localparam int     IDX_W          = sers_pkg::IDX_W;
   localparam int     LEN_W          = sers_pkg::LEN_W;
   localparam int     DEPTH_DEF      = sers_pkg::DEPTH_DEF;
   localparam int     RSP_DATA_W     = sers_pkg::RSP_DATA_W;
   localparam int     CSR_ADDR_W     = sers_pkg::CSR_ADDR_W;
   localparam int     CSR_DATA_W     = sers_pkg::CSR_DATA_W;
   localparam int     REQ_W          = ((IDX_W + 2*sers_pkg::WORD_WIDTH_DEF + 7)/8)*8;
   localparam int     SETTLE         = 30;
   localparam int     HOLD_CYCLES    = 300;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     TOTAL_ITEMS    = 1300;
   localparam longint WMIN           = -(64'sd1 <<< 31);
   localparam longint WMAX           = (64'sd1 <<< 31) - 1;

   typedef struct packed {
      logic               func;
      logic [IDX_W-1:0]   slot;
      logic signed [31:0] elem;
      logic signed [31:0] key;
   } search_req_type;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] last;
   } range_hit_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata   = '0;   // slot_index, element_value, search_value, pad
   logic                  req_tuser   = 1'b0; // func
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // first_index, last_index, pad
   logic                  rsp_tuser;          // found
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   search_req_type     req_backlog[$];
   range_hit_type      hits_due[$];
   search_req_type     cur_req;
   logic signed [31:0] shadow_mem [0:DEPTH_DEF-1];
   logic [LEN_W-1:0]   shadow_len = '0;
   longint             gen_mem [0:DEPTH_DEF-1];
   int                 reqs_queued = 0;
   int                 reqs_taken  = 0;
   int                 send_pause  = 0;
   int                 recv_pause  = 0;
   int                 holds_asked = 0;
   int                 holds_done  = 0;
   int                 hold_left   = 0;
   bit                 holding     = 1'b0;
   bit                 calm        = 1'b0;
   int                 n_err       = 0;
   int                 quiet       = 0;

   sorted_equal_range_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #1 clock = ~clock;

   function automatic int run_edge(int n, logic signed [31:0] key, bit first_side);
      int l, r, m;
      l = 0;
      r = n - 1;
      while (l <= r) begin
         m = l + (r - l) / 2;
         if (shadow_mem[m] > key || (first_side && shadow_mem[m] == key)) r = m - 1;
         else l = m + 1;
      end
      return r + 1;
   endfunction

   function automatic range_hit_type find_range(logic signed [31:0] key);
      int            n, lo, hi;
      range_hit_type hit;
      n   = (shadow_len > DEPTH_DEF) ? DEPTH_DEF : int'(shadow_len);
      lo  = run_edge(n, key, 1'b1);
      hi  = run_edge(n, key, 1'b0) - 1;
      hit = '0;
      if (lo <= hi && hi < n && lo >= 0 && shadow_mem[lo] == key && shadow_mem[hi] == key) begin
         hit.found = 1'b1;
         hit.first = lo[IDX_W-1:0];
         hit.last  = hi[IDX_W-1:0];
      end
      return hit;
   endfunction

   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic longint rand_between(longint lo, longint hi);
      return lo + (longint'($urandom) % (hi - lo + 1));
   endfunction

   function automatic longint choose_key(int n);
      int     r, k;
      longint v;
      r = $urandom_range(0, 99);
      k = (n > 0) ? $urandom_range(0, n - 1) : 0;
      if (n == 0 || r < 8) return rand_between(WMIN, WMAX);
      if (r < 12) return (r < 10) ? WMIN : WMAX;
      if (r < 30) begin
         v = gen_mem[k] + (r[0] ? 1 : -1);
         if (v > WMAX) v = WMAX;
         if (v < WMIN) v = WMIN;
         return v;
      end
      return gen_mem[k];
   endfunction

   task automatic push_write(input int slot, input longint val);
      search_req_type it;
      it.func = sers_pkg::FUNC_WRITE;
      it.slot = slot[IDX_W-1:0];
      it.elem = val[31:0];
      it.key  = $urandom;
      gen_mem[slot] = val;
      req_backlog.push_back(it);
      reqs_queued++;
   endtask

   task automatic push_query(input longint val);
      search_req_type it;
      it.func = sers_pkg::FUNC_QUERY;
      it.slot = IDX_W'($urandom_range(0, DEPTH_DEF - 1));
      it.elem = $urandom;
      it.key  = val[31:0];
      req_backlog.push_back(it);
      reqs_queued++;
   endtask

   task automatic drain();
      while (reqs_taken != reqs_queued || hits_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_length(input int len);
      drain();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {sers_pkg::REG_USED_LENGTH, 2'b00};
      csr_pwdata  <= len;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      shadow_len = len[LEN_W-1:0];
      calm = ($urandom_range(0, 3) == 0);
   endtask

   // request driver and search predictor
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_pause <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (cur_req.func == sers_pkg::FUNC_WRITE) shadow_mem[cur_req.slot] = cur_req.elem;
            else hits_due.push_back(find_range(cur_req.key));
            reqs_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_pause > 0) begin
               send_pause <= send_pause - 1;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               cur_req = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= cur_req.func;
               req_tdata  <= {{(REQ_W - IDX_W - 64){1'b0}}, cur_req.key, cur_req.elem,
                              cur_req.slot};
               send_pause <= pick_pause();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         holding   <= 1'b0;
         hold_left <= 0;
      end else if (holding) begin
         if (hold_left == 0) holding <= 1'b0;
         else hold_left <= hold_left - 1;
      end else if (holds_done != holds_asked) begin
         holding    <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // response monitor
   always @(posedge clock) begin
      range_hit_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_pause <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (hits_due.size() == 0) begin
               $error("unexpected response: found %0b tdata %h", rsp_tuser, rsp_tdata);
               n_err++;
            end else begin
               want = hits_due.pop_front();
               if (rsp_tuser !== want.found) begin
                  $error("found: expected %0b, actual %0b", want.found, rsp_tuser);
                  n_err++;
               end
               if (rsp_tdata[IDX_W-1:0] !== want.first) begin
                  $error("first_index: expected %0d, actual %0d", want.first,
                         rsp_tdata[IDX_W-1:0]);
                  n_err++;
               end
               if (rsp_tdata[2*IDX_W-1:IDX_W] !== want.last) begin
                  $error("last_index: expected %0d, actual %0d", want.last,
                         rsp_tdata[2*IDX_W-1:IDX_W]);
                  n_err++;
               end
            end
         end
         if (holding) begin
            rsp_tready <= 1'b0;
         end else if (recv_pause > 0) begin
            recv_pause <= recv_pause - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_pause <= pick_pause();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("tb_sorted_equal_range_search: done, errors");
         $finish;
      end
   end

   initial begin
      int       len, n, r, steps, k;
      longint   v, lo, hi, ceiling, base, span;
      longint   vals[$];

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_length(0);
      push_query(WMIN);
      push_query(WMAX);
      push_write(0, WMIN);
      push_write(1, WMIN);
      push_write(2, 0);
      push_write(3, WMAX);
      push_write(DEPTH_DEF - 1, WMAX);
      set_length(1);
      push_query(WMIN);
      push_query(0);
      set_length(4);
      push_query(WMIN);
      push_query(0);
      push_query(WMAX);
      push_query(-1);
      push_query(1);
      push_write(0, 7);
      push_query(7);
      push_query(WMIN);

      // fill the whole store in ascending order with runs of duplicates
      v = WMIN;
      for (int i = 0; i < DEPTH_DEF; i++) begin
         if (i == DEPTH_DEF - 1) v = WMAX;
         push_write(i, v);
         if ($urandom_range(0, 2) != 0) v = v + $urandom_range(1, 4200000);
         if (v > WMAX) v = WMAX;
      end
      set_length(DEPTH_DEF);
      calm = 1'b1;
      holds_asked++;
      repeat (60) push_query(choose_key(DEPTH_DEF));
      set_length(2047);
      repeat (20) push_query(choose_key(DEPTH_DEF));
      set_length(DEPTH_DEF + 1);
      repeat (10) push_query(choose_key(DEPTH_DEF));

      while (reqs_queued < TOTAL_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 60) len = (r < 45) ? $urandom_range(1, 16) : $urandom_range(17, 64);
         else if (r < 85) len = $urandom_range(65, DEPTH_DEF);
         else if (r < 92) len = 0;
         else len = $urandom_range(DEPTH_DEF + 1, 2047);
         set_length(len);
         n = (len > DEPTH_DEF) ? DEPTH_DEF : len;
         if (n > 0 && n <= 64) begin
            ceiling = (n < DEPTH_DEF) ? gen_mem[n] : WMAX;
            case ($urandom_range(0, 3))
               0: span = 3;
               1: span = 40;
               2: span = 100000;
               default: span = 64'sd1 <<< 32;
            endcase
            base = ceiling - span;
            if (base < WMIN) base = WMIN;
            vals.delete();
            for (int i = 0; i < n; i++) vals.push_back(rand_between(base, ceiling));
            vals.sort();
            for (int i = 0; i < n; i++) push_write(i, vals[i]);
         end
         if ($urandom_range(0, 9) == 0) holds_asked++;
         steps = $urandom_range(6, 20);
         repeat (steps) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               push_write($urandom_range(0, DEPTH_DEF - 1), rand_between(WMIN, WMAX));
            end else if (r < 16 && n > 0) begin
               k  = $urandom_range(0, n - 1);
               lo = (k > 0) ? gen_mem[k-1] : WMIN;
               hi = (k < DEPTH_DEF - 1) ? gen_mem[k+1] : WMAX;
               v  = (lo <= hi) ? rand_between(lo, hi) : gen_mem[k];
               push_write(k, v);
               push_query(v);
            end else begin
               push_query(choose_key(n));
            end
         end
      end

      drain();
      if (n_err == 0) begin
         $display("tb_sorted_equal_range_search: done, clean");
      end else begin
         $display("tb_sorted_equal_range_search: done, errors");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/sers_pkg.sv
rtl/sers_ram.sv
rtl/sorted_equal_range_search.sv
rtl/sers_checker.sv
tb/tb_sorted_equal_range_search.sv
